>>> rtl/rsd_pkg.sv
// Shared types and constants for the radial spotlight dimmer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package rsd_pkg;

	// Default widths of the pixel fields.
	localparam int COORD_BITS_DEF = 12;
	localparam int LUMA_BITS_DEF  = 16;

	// Configuration registers.
	localparam int CENTER_BITS    = 14;
	localparam int CFG_INDEX_BITS = 1;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_CENTER_X = 1'b0,
		REG_CENTER_Y = 1'b1
	} cfg_reg_t;

	// Distance arithmetic. Offsets under the limit fit in AXIS_BITS, so the
	// scaled sum of squares fits in RAD_BITS and its root in ROOT_BITS.
	localparam int LIMIT_PIX = 160;
	localparam int AXIS_BITS = 8;
	localparam int SUM_BITS  = 2 * AXIS_BITS;
	localparam int RAD_BITS  = SUM_BITS + 8;
	localparam int ROOT_BITS = RAD_BITS / 2;
	localparam int REM_BITS  = ROOT_BITS + 2;

	// Distance in Q8.4 saturates at 160 pixels.
	localparam int DIST_BITS = ROOT_BITS;
	localparam logic [DIST_BITS-1:0] DIST_SAT = DIST_BITS'(2560);

	// Dimming divisor 3200 = 2^7 * 25.
	localparam int DIV_SHIFT = 7;
	localparam int DIV_ODD   = 25;

	// Work carried from cell to cell of the square root chain.
	typedef struct packed {
		logic [RAD_BITS-1:0]  rad;
		logic [REM_BITS-1:0]  rem;
		logic [ROOT_BITS-1:0] root;
		logic                 sat;
	} sqrt_work_t;

endpackage

`default_nettype wire

>>> rtl/rsd_offset.sv
// Front end of the dimmer: offsets to the center, saturation test and sum of squares.
// Depends on rsd_pkg.
`default_nettype none

module rsd_offset import rsd_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int LUMA_BITS  = LUMA_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic signed [CENTER_BITS-1:0] center_x,
	input  wire logic signed [CENTER_BITS-1:0] center_y,
	input  wire logic                          up_valid,
	output logic                               up_ready,
	input  wire logic [COORD_BITS-1:0]         up_x,
	input  wire logic [COORD_BITS-1:0]         up_y,
	input  wire logic [LUMA_BITS-1:0]          up_luma,
	output logic                               dn_valid,
	input  wire logic                          dn_ready,
	output sqrt_work_t                         dn_work,
	output logic [LUMA_BITS-1:0]               dn_luma
);

	// Signed difference width: wide enough for any coordinate minus any center.
	localparam int DW = ((COORD_BITS > CENTER_BITS) ? COORD_BITS : CENTER_BITS) + 2;

	logic signed [DW-1:0] dx, dy;
	logic [DW-1:0]        ax, ay;
	logic                 sat;

	logic                 valid_s1, valid_s2;
	logic                 ready_s1, ready_s2;
	logic                 sat_s1;
	logic [AXIS_BITS-1:0] ax_s1, ay_s1;
	logic [LUMA_BITS-1:0] luma_s1;
	logic [SUM_BITS:0]    sum;
	sqrt_work_t           work_s2;
	logic [LUMA_BITS-1:0] luma_s2;

	always_comb begin
		dx  = $signed({{(DW-COORD_BITS){1'b0}}, up_x}) - DW'(center_x);
		dy  = $signed({{(DW-COORD_BITS){1'b0}}, up_y}) - DW'(center_y);
		ax  = dx[DW-1] ? DW'(-dx) : DW'(dx);
		ay  = dy[DW-1] ? DW'(-dy) : DW'(dy);
		sat = (ax >= DW'(LIMIT_PIX)) || (ay >= DW'(LIMIT_PIX));
	end

	// Out of range offsets leave garbage in the sum; the saturation flag overrides it.
	assign sum = (SUM_BITS+1)'(ax_s1 * ax_s1) + (SUM_BITS+1)'(ay_s1 * ay_s1);

	assign ready_s2 = !valid_s2 || dn_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign up_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= up_valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && up_valid) begin
			sat_s1  <= sat;
			ax_s1   <= ax[AXIS_BITS-1:0];
			ay_s1   <= ay[AXIS_BITS-1:0];
			luma_s1 <= up_luma;
		end
		if (ready_s2 && valid_s1) begin
			work_s2.rad  <= {sum[SUM_BITS-1:0], {(RAD_BITS-SUM_BITS){1'b0}}};
			work_s2.rem  <= '0;
			work_s2.root <= '0;
			work_s2.sat  <= sat_s1;
			luma_s2      <= luma_s1;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_work  = work_s2;
	assign dn_luma  = luma_s2;

endmodule

`default_nettype wire

>>> rtl/rsd_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per cycle while the next cell takes its output.
// Depends on rsd_pkg.
`default_nettype none

module rsd_sqrt_cell import rsd_pkg::*; #(
	parameter int LUMA_BITS = LUMA_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 up_valid,
	output logic                      up_ready,
	input  wire sqrt_work_t           up_work,
	input  wire logic [LUMA_BITS-1:0] up_luma,
	output logic                      dn_valid,
	input  wire logic                 dn_ready,
	output sqrt_work_t                dn_work,
	output logic [LUMA_BITS-1:0]      dn_luma
);

	logic [REM_BITS-1:0] rem_sh, trial;
	logic                fits;
	sqrt_work_t          next;
	logic                valid_q;
	sqrt_work_t          work_q;
	logic [LUMA_BITS-1:0] luma_q;

	// Bring down the next two radicand bits and try appending a one to the root.
	always_comb begin
		rem_sh    = {up_work.rem[REM_BITS-3:0], up_work.rad[RAD_BITS-1 -: 2]};
		trial     = {up_work.root[ROOT_BITS-1:0], 2'b01};
		fits      = rem_sh >= trial;
		next.rad  = {up_work.rad[RAD_BITS-3:0], 2'b00};
		next.rem  = fits ? rem_sh - trial : rem_sh;
		next.root = {up_work.root[ROOT_BITS-2:0], fits};
		next.sat  = up_work.sat;
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			work_q <= next;
			luma_q <= up_luma;
		end
	end

	assign dn_valid = valid_q;
	assign dn_work  = work_q;
	assign dn_luma  = luma_q;

endmodule

`default_nettype wire

>>> rtl/rsd_dim.sv
// Back end of the dimmer: distance clamp, luminance product, division by 3200
// through a reciprocal, and the subtraction in the output register. Depends on rsd_pkg.
`default_nettype none

module rsd_dim import rsd_pkg::*; #(
	parameter int LUMA_BITS = LUMA_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 up_valid,
	output logic                      up_ready,
	input  wire sqrt_work_t           up_work,
	input  wire logic [LUMA_BITS-1:0] up_luma,
	output logic                      dn_valid,
	input  wire logic                 dn_ready,
	output logic [LUMA_BITS-1:0]      dn_luma
);

	// q = p >> 7 has QW bits; floor(q / 25) = (q * RECIP) >> SH for every q below 2^QW.
	localparam int PW = LUMA_BITS + DIST_BITS;
	localparam int QW = PW - DIV_SHIFT;
	localparam int SH = QW + $clog2(DIV_ODD);
	localparam logic [63:0] RECIP_FULL = ((64'd1 << SH) + 64'(DIV_ODD - 1)) / 64'(DIV_ODD);
	localparam logic [QW:0] RECIP = RECIP_FULL[QW:0];
	localparam int MW = 2 * QW + 1;

	logic [DIST_BITS-1:0] dist_clip;
	logic                 ready_s1, ready_s2, ready_s3;
	logic                 valid_s1, valid_s2, valid_q;
	logic [PW-1:0]        prod_s1;
	logic [LUMA_BITS-1:0] luma_s1, luma_s2, luma_q;
	logic [MW-1:0]        quot_s2;
	logic [MW-SH-1:0]     dim;

	always_comb begin
		if (up_work.sat || (up_work.root >= DIST_SAT)) dist_clip = DIST_SAT;
		else dist_clip = up_work.root[DIST_BITS-1:0];
	end

	assign dim = quot_s2[MW-1:SH];

	assign ready_s3 = !valid_q || dn_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign up_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= up_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_q  <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && up_valid) begin
			prod_s1 <= PW'(up_luma) * PW'(dist_clip);
			luma_s1 <= up_luma;
		end
		if (ready_s2 && valid_s1) begin
			quot_s2 <= MW'(prod_s1[PW-1:DIV_SHIFT]) * MW'(RECIP);
			luma_s2 <= luma_s1;
		end
		if (ready_s3 && valid_s2) begin
			luma_q <= luma_s2 - dim[LUMA_BITS-1:0];
		end
	end

	assign dn_valid = valid_q;
	assign dn_luma  = luma_q;

endmodule

`default_nettype wire

>>> rtl/radial_spotlight_dimmer_unit.sv
// Top level of the radial spotlight dimmer: center registers and the pipeline.
// Depends on rsd_pkg, rsd_offset, rsd_sqrt_cell and rsd_dim.
`default_nettype none

// Channel    Direction  Handshake           Beat contents
// -------    ---------  ------------------  ---------------------------
// input      in         in_valid/in_stall   pixel_x, pixel_y, luma_in
// output     out        out_valid/out_stall luma_out
// config     in         cfg_write           cfg_index, cfg_data
//
// One beat is taken every cycle until a stall on the output has filled every stage. A beat
// accepted at the input reaches luma_out through 17 registers: two front end stages, twelve
// square root cells (one root bit each) and three back end stages.
// Reset clears every valid bit and sets both center coordinates to zero.
// A stall on the output holds the final register; each stage keeps loading while
// the one ahead of it is empty, so in_stall rises only once every stage is full.

module radial_spotlight_dimmer_unit import rsd_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int LUMA_BITS  = LUMA_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_write,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CENTER_BITS-1:0]    cfg_data,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [COORD_BITS-1:0]     pixel_x,
	input  wire logic [COORD_BITS-1:0]     pixel_y,
	input  wire logic [LUMA_BITS-1:0]      luma_in,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [LUMA_BITS-1:0]           luma_out
);

	// One cell per bit of the root.
	localparam int NCELL = ROOT_BITS;

	logic signed [CENTER_BITS-1:0] center_x_q, center_y_q;

	// Chain links: link 0 feeds the first cell, link NCELL leaves the last one.
	logic                 link_valid [NCELL+1];
	logic                 link_ready [NCELL+1];
	sqrt_work_t           link_work  [NCELL+1];
	logic [LUMA_BITS-1:0] link_luma  [NCELL+1];

	logic front_ready;
	logic back_ready;

	// Center registers. Writes must arrive only while the pipeline is empty; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_CENTER_X: center_x_q <= cfg_data;
				REG_CENTER_Y: center_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = !front_ready;

	// Offsets, saturation and the sum of squares.
	rsd_offset #(
		.COORD_BITS(COORD_BITS),
		.LUMA_BITS (LUMA_BITS)
	) u_offset (
		.clk     (clk),
		.arst_n  (arst_n),
		.center_x(center_x_q),
		.center_y(center_y_q),
		.up_valid(in_valid),
		.up_ready(front_ready),
		.up_x    (pixel_x),
		.up_y    (pixel_y),
		.up_luma (luma_in),
		.dn_valid(link_valid[0]),
		.dn_ready(link_ready[0]),
		.dn_work (link_work[0]),
		.dn_luma (link_luma[0])
	);

	// The square root runs down a row of identical cells, most significant bit first.
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		rsd_sqrt_cell #(
			.LUMA_BITS(LUMA_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.up_valid(link_valid[i]),
			.up_ready(link_ready[i]),
			.up_work (link_work[i]),
			.up_luma (link_luma[i]),
			.dn_valid(link_valid[i+1]),
			.dn_ready(link_ready[i+1]),
			.dn_work (link_work[i+1]),
			.dn_luma (link_luma[i+1])
		);
	end

	assign link_ready[NCELL] = back_ready;

	// Clamp, scale and subtract; the last register here drives the output.
	rsd_dim #(
		.LUMA_BITS(LUMA_BITS)
	) u_dim (
		.clk     (clk),
		.arst_n  (arst_n),
		.up_valid(link_valid[NCELL]),
		.up_ready(back_ready),
		.up_work (link_work[NCELL]),
		.up_luma (link_luma[NCELL]),
		.dn_valid(out_valid),
		.dn_ready(!out_stall),
		.dn_luma (luma_out)
	);

endmodule

`default_nettype wire

>>> tb/radial_spotlight_dimmer_unit_tb.sv
// Self-checking testbench for radial_spotlight_dimmer_unit: directed corner pixels, then
// random pixel streams under several centers with idle and stall mixes on both channels.
// Depends on rsd_pkg and the radial_spotlight_dimmer_unit RTL; reads no files.
`default_nettype none

module radial_spotlight_dimmer_unit_tb;
	import rsd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_W = COORD_BITS_DEF;
	localparam int LUMA_W  = LUMA_BITS_DEF;

	// Dimming law: distance in Q8.4, clipped at 160 pixels, and a divisor of 3200
	// so that every pixel of distance removes half a percent of the luminance.
	localparam int RING_LIMIT  = 160;
	localparam int DIST_FULL   = 2560;
	localparam int DIM_DIVISOR = 3200;

	// The pipeline is 17 stages deep; the settle wait adds margin for any straggler.
	localparam int SETTLE_CYCLES = 20;
	localparam int DRAIN_LIMIT   = 5000;

	// This run limit lies far beyond the slowest correct run.
	localparam int RUN_LIMIT_NS = 400_000;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [LUMA_W-1:0]  luma_t;

	// Holds the center registers as the block should see them and the queue of
	// luminance values still to come out of the pipeline, oldest first.
	class dimmer_scoreboard;
		int     center_x;
		int     center_y;
		luma_t  expected_luma[$];
		int     errors;
		int     checked;

		function void set_center(cfg_reg_t idx, logic [CENTER_BITS-1:0] v);
			case (idx)
				REG_CENTER_X: center_x = $signed(v);
				REG_CENTER_Y: center_y = $signed(v);
				default: ;
			endcase
		endfunction

		// Bit-exact prediction of one pixel's dimmed luminance.
		function luma_t dimmed_luma(coord_t px, coord_t py, luma_t l);
			int dx, dy, ax, ay;
			int unsigned rad, dist_q4, trial;
			longint unsigned cut;
			dx = int'(px) - center_x;
			dy = int'(py) - center_y;
			ax = (dx < 0) ? -dx : dx;
			ay = (dy < 0) ? -dy : dy;
			if (ax >= RING_LIMIT || ay >= RING_LIMIT) begin
				dist_q4 = DIST_FULL;
			end else begin
				// Floor square root of the squared distance scaled by 256,
				// built one bit at a time from the top.
				rad = (ax * ax + ay * ay) << 8;
				dist_q4 = 0;
				for (int b = 11; b >= 0; b--) begin
					trial = dist_q4 | (32'd1 << b);
					if (trial * trial <= rad)
						dist_q4 = trial;
				end
				if (dist_q4 >= DIST_FULL)
					dist_q4 = DIST_FULL;
			end
			cut = (longint'(l) * longint'(dist_q4)) / DIM_DIVISOR;
			return luma_t'(longint'(l) - cut);
		endfunction

		function void note_pixel(coord_t px, coord_t py, luma_t l);
			expected_luma.push_back(dimmed_luma(px, py, l));
		endfunction

		function void check_luma(luma_t got);
			luma_t want;
			if (expected_luma.size() == 0) begin
				$error("luma_out: expected no beat, actual %h", got);
				errors++;
				return;
			end
			want = expected_luma.pop_front();
			checked++;
			if (got !== want) begin
				$error("luma_out: expected %h, actual %h", want, got);
				errors++;
			end
		endfunction

		function int pending();
			return expected_luma.size();
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_write;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CENTER_BITS-1:0]    cfg_data;
	logic                      in_valid;
	logic                      in_stall;
	coord_t                    pixel_x;
	coord_t                    pixel_y;
	luma_t                     luma_in;
	logic                      out_valid;
	logic                      out_stall;
	luma_t                     luma_out;

	dimmer_scoreboard sb;

	// Traffic shaping knobs, in percent of cycles, plus a one-shot output hold.
	int tx_idle_pct;
	int rx_stall_pct;
	int hold_cycles;

	int pixels_sent;
	int center_writes;
	int input_stall_cycles;

	radial_spotlight_dimmer_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.luma_in   (luma_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.luma_out  (luma_out)
	);

	always #2 clk = ~clk;

	// Output side. A pending hold takes priority and is counted down here at
	// every falling edge; otherwise the stall is drawn at the current rate.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles--;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
		end
	end

	// Every output beat taken at a rising edge is checked against the oldest
	// prediction. Input-side back-pressure is counted to show the hold did fill
	// the pipeline.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_luma(luma_out);
			if (in_valid && in_stall)
				input_stall_cycles++;
		end
	end

	// Offers one pixel beat, after a random number of idle cycles, and returns at
	// the rising edge that accepts it. Valid stays high on return so that a
	// back-to-back beat simply swaps the payload at the next falling edge.
	task automatic send_pixel(coord_t px, coord_t py, luma_t l);
		int gap;
		gap = 0;
		while (tx_idle_pct > 0 && gap < 8 && $urandom_range(0, 99) < tx_idle_pct)
			gap++;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		pixel_x  <= px;
		pixel_y  <= py;
		luma_in  <= l;
		do @(posedge clk); while (in_stall);
		sb.note_pixel(px, py, l);
		pixels_sent++;
	endtask

	// Stops offering beats and waits for every predicted result, then lets the
	// pipeline settle so that the block is idle.
	task automatic drain_pipeline();
		@(negedge clk);
		in_valid <= 1'b0;
		for (int i = 0; i < DRAIN_LIMIT && sb.pending() != 0; i++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Moves the spotlight. Only done with the pipeline empty.
	task automatic write_center(int cx, int cy);
		drain_pipeline();
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= REG_CENTER_X;
		cfg_data  <= cx[CENTER_BITS-1:0];
		sb.set_center(REG_CENTER_X, cx[CENTER_BITS-1:0]);
		@(negedge clk);
		cfg_index <= REG_CENTER_Y;
		cfg_data  <= cy[CENTER_BITS-1:0];
		sb.set_center(REG_CENTER_Y, cy[CENTER_BITS-1:0]);
		@(negedge clk);
		cfg_write <= 1'b0;
		center_writes++;
	endtask

	// A stream of random pixels. Three in four land within a little more than
	// the dimming radius of the center, so the square root sees real work; the
	// rest are anywhere in the frame. Luminance favors full scale and zero now
	// and then.
	task automatic run_stream(int n_items, int tx_pct, int rx_pct);
		int px, py;
		luma_t l;
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(0, 3) != 0) begin
				px = sb.center_x + int'($urandom_range(0, 340)) - 170;
				py = sb.center_y + int'($urandom_range(0, 340)) - 170;
				px = (px < 0) ? 0 : (px > 4095) ? 4095 : px;
				py = (py < 0) ? 0 : (py > 4095) ? 4095 : py;
			end else begin
				px = $urandom_range(0, 4095);
				py = $urandom_range(0, 4095);
			end
			case ($urandom_range(0, 9))
				0:       l = '1;
				1:       l = '0;
				default: l = luma_t'($urandom());
			endcase
			send_pixel(coord_t'(px), coord_t'(py), l);
		end
	endtask

	initial begin
		#(RUN_LIMIT_NS * 1ns);
		$display("radial_spotlight_dimmer_unit regression: fail");
		$finish;
	end

	initial begin
		int cx, cy;
		sb = new();
		arst_n       = 1'b0;
		cfg_write    = 1'b0;
		cfg_index    = REG_CENTER_X;
		cfg_data     = '0;
		in_valid     = 1'b0;
		pixel_x      = '0;
		pixel_y      = '0;
		luma_in      = '0;
		out_stall    = 1'b0;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		hold_cycles  = 0;
		pixels_sent  = 0;
		center_writes      = 0;
		input_stall_cycles = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Center at its reset value of the origin: no dimming at the center, a
		// 3-4-5 triangle, and the far corner fully dimmed.
		send_pixel(12'd0, 12'd0, 16'hFFFF);
		send_pixel(12'd3, 12'd4, 16'h8000);
		send_pixel(12'd4095, 12'd4095, 16'hFFFF);

		// Around a center inside the frame: offsets just inside and at the axis
		// limit on both sides, the diagonal that just stays under the ring and the
		// one that crosses it, and a 96-128 offset that lands on exactly 160.
		write_center(200, 300);
		send_pixel(12'd200, 12'd300, 16'h0000);
		send_pixel(12'd359, 12'd300, 16'hFFFF);
		send_pixel(12'd360, 12'd300, 16'hFFFF);
		send_pixel(12'd41, 12'd300, 16'hFFFF);
		send_pixel(12'd200, 12'd140, 16'h1234);
		send_pixel(12'd313, 12'd413, 16'hFFFF);
		send_pixel(12'd314, 12'd414, 16'hFFFF);
		send_pixel(12'd296, 12'd428, 16'hFFFF);
		send_pixel(12'd201, 12'd301, 16'h0001);
		send_pixel(12'd200, 12'd301, 16'hAAAA);
		send_pixel(12'd200, 12'd300, 16'h5555);

		// Centers outside the frame, at both extremes of the register range. The
		// offsets must be exact signed differences with no wrap.
		write_center(-8192, 8191);
		send_pixel(12'd0, 12'd0, 16'hFFFF);
		send_pixel(12'd4095, 12'd4095, 16'hC3C3);
		write_center(-5, 4102);
		send_pixel(12'd0, 12'd4095, 16'hFFFF);
		send_pixel(12'd150, 12'd4095, 16'hFFFF);
		write_center(8191, -1);
		send_pixel(12'd4095, 12'd0, 16'hFFFF);
		write_center(-1, -8192);
		send_pixel(12'd0, 12'd0, 16'h7FFF);
		send_pixel(12'd100, 12'd50, 16'hFFFF);

		// Random streams: a fresh center per phase, cycling through no idling,
		// sender idling, receiver stalling, and both.
		for (int phase = 0; phase < 8; phase++) begin
			if ($urandom_range(0, 3) != 0) begin
				cx = $urandom_range(0, 4095);
				cy = $urandom_range(0, 4095);
			end else begin
				cx = int'($urandom_range(0, 16383)) - 8192;
				cy = int'($urandom_range(0, 16383)) - 8192;
			end
			write_center(cx, cy);
			case (phase % 4)
				0: run_stream(40, 0, 0);
				1: run_stream(40, 50, 0);
				2: run_stream(40, 0, 50);
				default: run_stream(40, 25, 25);
			endcase
		end

		// Back-pressure: the receiver holds off for a long stretch while pixels
		// keep coming every cycle, so the pipeline fills and in_stall must rise
		// without losing or duplicating a beat.
		write_center($urandom_range(200, 3800), $urandom_range(200, 3800));
		hold_cycles = 150;
		run_stream(60, 0, 0);

		drain_pipeline();
		if (sb.pending() != 0) begin
			$error("luma_out: expected %0d more beats, actual none", sb.pending());
			sb.errors++;
		end

		$display("Ran %0d pixels over %0d spotlight centers; %0d results checked.",
			pixels_sent, center_writes, sb.checked);
		$display("Traffic mixed idle and stall rates; input held off for %0d cycles.",
			input_stall_cycles);
		if (sb.errors == 0) begin
			$display("radial_spotlight_dimmer_unit regression: pass");
		end else begin
			$display("radial_spotlight_dimmer_unit regression: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire

>>> sim.f
rtl/rsd_pkg.sv
rtl/rsd_offset.sv
rtl/rsd_sqrt_cell.sv
rtl/rsd_dim.sv
rtl/radial_spotlight_dimmer_unit.sv
tb/radial_spotlight_dimmer_unit_tb.sv
